FILE: sv/obv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obv_pkg
// Shared types, register map and helpers for the obstacle box vertices block.
// ----------------------------------------------------------------------------
package obv_pkg;

    localparam int W_LEN  = 24;  // Q15.8 lengths and positions
    localparam int W_REG  = 23;  // unsigned extent registers
    localparam int W_TRIG = 16;  // Q1.14 heading cosine and sine
    localparam int W_EXT  = 25;  // extent after the reduction, signed
    localparam int W_ADDR = 5;

    localparam logic signed [W_EXT-1:0] REDUCTION = 25'sd128;
    localparam logic signed [40:0]      RND_HALF  = 41'sd8192;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MAX_BOW        = 3'd0;
    localparam logic [2:0] REG_MAX_STERN      = 3'd1;
    localparam logic [2:0] REG_MAX_STARBOARD  = 3'd2;
    localparam logic [2:0] REG_MAX_PORT       = 3'd3;
    localparam logic [2:0] REG_SAFE_BOW       = 3'd4;
    localparam logic [2:0] REG_SAFE_STERN     = 3'd5;
    localparam logic [2:0] REG_SAFE_STARBOARD = 3'd6;
    localparam logic [2:0] REG_SAFE_PORT      = 3'd7;

    // corner codes
    localparam logic [1:0] CORNER_FR = 2'd0;
    localparam logic [1:0] CORNER_FL = 2'd1;
    localparam logic [1:0] CORNER_RR = 2'd2;
    localparam logic [1:0] CORNER_RL = 2'd3;

    typedef struct packed {
        logic [W_REG-1:0] max_bow;
        logic [W_REG-1:0] max_stern;
        logic [W_REG-1:0] max_starboard;
        logic [W_REG-1:0] max_port;
        logic [W_REG-1:0] safe_bow;
        logic [W_REG-1:0] safe_stern;
        logic [W_REG-1:0] safe_starboard;
        logic [W_REG-1:0] safe_port;
    } t_cfg;

    // box extents of one obstacle plus what the rotation needs
    typedef struct packed {
        logic [W_EXT-1:0]  bow;
        logic [W_EXT-1:0]  stern;
        logic [W_EXT-1:0]  sb;
        logic [W_EXT-1:0]  pt;
        logic [W_LEN-1:0]  ox;
        logic [W_LEN-1:0]  oy;
        logic [W_TRIG-1:0] hc;
        logic [W_TRIG-1:0] hs;
    } t_box;

    // one corner on its way through the rotation
    typedef struct packed {
        logic [1:0]        corner;
        logic              last;
        logic [W_LEN-1:0]  lx;
        logic [W_LEN-1:0]  ly;
        logic [W_LEN-1:0]  ox;
        logic [W_LEN-1:0]  oy;
        logic [W_TRIG-1:0] hc;
        logic [W_TRIG-1:0] hs;
    } t_vert;

    typedef struct packed {
        logic [1:0]       corner;
        logic             last;
        logic [W_LEN-1:0] lx;
        logic [W_LEN-1:0] ly;
        logic [W_LEN-1:0] ax;
        logic [W_LEN-1:0] ay;
    } t_vout;

    function automatic logic [W_LEN-1:0] sat24(input logic signed [27:0] v);
        logic [W_LEN-1:0] r;
        if (v > 28'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[W_LEN-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/obv_extent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obv_extent
// Three-stage pipeline that picks the four box extents from the vehicle
// position: capture, distance and compares, selection and reduction.
// ----------------------------------------------------------------------------
module obv_extent (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire obv_pkg::t_cfg         i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [127:0]          i_data,   // rel_x, rel_y, obs_x, obs_y, cos, sin
    input  wire logic                  i_comp,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output obv_pkg::t_box              o_box
);
    import obv_pkg::*;

    logic s1_rdy, s2_rdy, s3_rdy;
    logic r_s1_valid, r_s2_valid, r_s3_valid;

    // stage 1: captured item
    logic signed [W_LEN-1:0] r_s1_rx, r_s1_ry;
    logic                    r_s1_comp;
    logic [W_LEN-1:0]        r_s1_ox, r_s1_oy;
    logic [W_TRIG-1:0]       r_s1_hc, r_s1_hs;

    // stage 2: side, distance and compares
    logic                    r_s2_ahead, r_s2_stbd, r_s2_comp;
    logic [W_LEN-1:0]        r_s2_dx, r_s2_dy;
    logic                    r_s2_x_in, r_s2_x_out, r_s2_y_in, r_s2_y_out;
    logic [W_LEN-1:0]        r_s2_ox, r_s2_oy;
    logic [W_TRIG-1:0]       r_s2_hc, r_s2_hs;

    t_box r_s3;

    logic [W_LEN:0]    neg_x, neg_y;
    logic [W_LEN-1:0]  dx, dy;
    logic [W_REG-1:0]  xm, xs, ym, ys;
    logic              ahead, stbd;

    logic [W_REG-1:0]        xm3, xs3, ym3, ys3;
    logic                    x_mid, y_mid;
    logic signed [W_EXT-1:0] bx, by, bow, stern, sb, pt;

    assign s3_rdy  = !r_s3_valid || i_ready;
    assign s2_rdy  = !r_s2_valid || s3_rdy;
    assign s1_rdy  = !r_s1_valid || s2_rdy;
    assign o_ready = s1_rdy;
    assign o_valid = r_s3_valid;
    assign o_box   = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_valid <= i_valid;
            if (s2_rdy) r_s2_valid <= r_s1_valid;
            if (s3_rdy) r_s3_valid <= r_s2_valid;
        end
    end

    // stage 2 logic
    always_comb begin
        ahead = !r_s1_rx[W_LEN-1];
        stbd  = r_s1_ry[W_LEN-1];
        neg_x = -{r_s1_rx[W_LEN-1], r_s1_rx};
        neg_y = -{r_s1_ry[W_LEN-1], r_s1_ry};
        dx    = ahead ? r_s1_rx : neg_x[W_LEN-1:0];
        dy    = stbd ? neg_y[W_LEN-1:0] : r_s1_ry;
        xm    = ahead ? i_cfg.max_bow  : i_cfg.max_stern;
        xs    = ahead ? i_cfg.safe_bow : i_cfg.safe_stern;
        ym    = stbd  ? i_cfg.max_starboard  : i_cfg.max_port;
        ys    = stbd  ? i_cfg.safe_starboard : i_cfg.safe_port;
    end

    // stage 3 logic
    always_comb begin
        xm3   = r_s2_ahead ? i_cfg.max_bow  : i_cfg.max_stern;
        xs3   = r_s2_ahead ? i_cfg.safe_bow : i_cfg.safe_stern;
        ym3   = r_s2_stbd  ? i_cfg.max_starboard  : i_cfg.max_port;
        ys3   = r_s2_stbd  ? i_cfg.safe_starboard : i_cfg.safe_port;
        x_mid = !r_s2_x_in && !r_s2_x_out;
        y_mid = !r_s2_y_in && !r_s2_y_out;

        if (x_mid && !r_s2_y_out) begin
            bx = $signed({1'b0, r_s2_dx});
        end else if (r_s2_x_in && !r_s2_y_out) begin
            bx = $signed({2'b00, xs3});
        end else begin
            bx = $signed({2'b00, xm3});
        end

        if (y_mid && !r_s2_x_out) begin
            by = $signed({1'b0, r_s2_dy});
        end else if (r_s2_y_in && !r_s2_x_out) begin
            by = $signed({2'b00, ys3});
        end else begin
            by = $signed({2'b00, ym3});
        end

        // the far side of each axis keeps its maximum extent
        bow   = r_s2_ahead ? bx : $signed({2'b00, i_cfg.max_bow});
        stern = r_s2_ahead ? $signed({2'b00, i_cfg.max_stern}) : bx;
        sb    = r_s2_stbd  ? by : $signed({2'b00, i_cfg.max_starboard});
        pt    = r_s2_stbd  ? $signed({2'b00, i_cfg.max_port}) : by;

        if (!r_s2_comp) begin
            bow   = bow   - REDUCTION;
            stern = stern - REDUCTION;
            sb    = sb    - REDUCTION;
            pt    = pt    - REDUCTION;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_s1_rx   <= i_data[23:0];
            r_s1_ry   <= i_data[47:24];
            r_s1_ox   <= i_data[71:48];
            r_s1_oy   <= i_data[95:72];
            r_s1_hc   <= i_data[111:96];
            r_s1_hs   <= i_data[127:112];
            r_s1_comp <= i_comp;
        end
        if (s2_rdy && r_s1_valid) begin
            r_s2_ahead <= ahead;
            r_s2_stbd  <= stbd;
            r_s2_comp  <= r_s1_comp;
            r_s2_dx    <= dx;
            r_s2_dy    <= dy;
            r_s2_x_in  <= dx <= {1'b0, xs};
            r_s2_x_out <= dx >= {1'b0, xm};
            r_s2_y_in  <= dy <= {1'b0, ys};
            r_s2_y_out <= dy >= {1'b0, ym};
            r_s2_ox    <= r_s1_ox;
            r_s2_oy    <= r_s1_oy;
            r_s2_hc    <= r_s1_hc;
            r_s2_hs    <= r_s1_hs;
        end
        if (s3_rdy && r_s2_valid) begin
            r_s3.bow   <= bow;
            r_s3.stern <= stern;
            r_s3.sb    <= sb;
            r_s3.pt    <= pt;
            r_s3.ox    <= r_s2_ox;
            r_s3.oy    <= r_s2_oy;
            r_s3.hc    <= r_s2_hc;
            r_s3.hs    <= r_s2_hs;
        end
    end

endmodule
`default_nettype wire

FILE: sv/obv_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obv_rotate
// Corner rotation pipeline: corner register, products, rounded sums, then
// translation with saturation into the output register.
// ----------------------------------------------------------------------------
module obv_rotate (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire obv_pkg::t_vert i_vert,
    input  wire logic           i_out_ready,
    output logic                o_en,
    output logic                o_valid,
    output obv_pkg::t_vout      o_vout
);
    import obv_pkg::*;

    logic en;
    logic r_v0_valid, r_v1_valid, r_v2_valid, r_v3_valid;

    t_vert r_v0;

    // stage 1: products
    logic signed [39:0]  r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic [1:0]          r_v1_corner, r_v2_corner;
    logic                r_v1_last, r_v2_last;
    logic [W_LEN-1:0]    r_v1_lx, r_v1_ly, r_v1_ox, r_v1_oy;
    logic [W_LEN-1:0]    r_v2_lx, r_v2_ly, r_v2_ox, r_v2_oy;

    // stage 2: rounded rotation
    logic signed [26:0]  r_rot_x, r_rot_y;

    t_vout r_v3;

    logic signed [W_TRIG-1:0] hc, hs;
    logic signed [W_LEN-1:0]  lx, ly;
    logic signed [40:0]       sum_x, sum_y;
    logic signed [27:0]       ax, ay;

    assign en      = !r_v3_valid || i_out_ready;
    assign o_en    = en;
    assign o_valid = r_v3_valid;
    assign o_vout  = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0_valid <= 1'b0;
            r_v1_valid <= 1'b0;
            r_v2_valid <= 1'b0;
            r_v3_valid <= 1'b0;
        end else if (en) begin
            r_v0_valid <= i_valid;
            r_v1_valid <= r_v0_valid;
            r_v2_valid <= r_v1_valid;
            r_v3_valid <= r_v2_valid;
        end
    end

    always_comb begin
        hc = $signed(r_v0.hc);
        hs = $signed(r_v0.hs);
        lx = $signed(r_v0.lx);
        ly = $signed(r_v0.ly);
        // floor((v + 2^13) / 2^14) rounds halves toward plus infinity
        sum_x = {r_p_xc[39], r_p_xc} - {r_p_ys[39], r_p_ys} + RND_HALF;
        sum_y = {r_p_xs[39], r_p_xs} + {r_p_yc[39], r_p_yc} + RND_HALF;
        ax = $signed({{4{r_v2_ox[W_LEN-1]}}, r_v2_ox}) + $signed({r_rot_x[26], r_rot_x});
        ay = $signed({{4{r_v2_oy[W_LEN-1]}}, r_v2_oy}) + $signed({r_rot_y[26], r_rot_y});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v0 <= i_vert;

            r_p_xc      <= hc * lx;
            r_p_ys      <= hs * ly;
            r_p_xs      <= hs * lx;
            r_p_yc      <= hc * ly;
            r_v1_corner <= r_v0.corner;
            r_v1_last   <= r_v0.last;
            r_v1_lx     <= r_v0.lx;
            r_v1_ly     <= r_v0.ly;
            r_v1_ox     <= r_v0.ox;
            r_v1_oy     <= r_v0.oy;

            r_rot_x     <= sum_x[40:14];
            r_rot_y     <= sum_y[40:14];
            r_v2_corner <= r_v1_corner;
            r_v2_last   <= r_v1_last;
            r_v2_lx     <= r_v1_lx;
            r_v2_ly     <= r_v1_ly;
            r_v2_ox     <= r_v1_ox;
            r_v2_oy     <= r_v1_oy;

            r_v3.corner <= r_v2_corner;
            r_v3.last   <= r_v2_last;
            r_v3.lx     <= r_v2_lx;
            r_v3.ly     <= r_v2_ly;
            r_v3.ax     <= sat24(ax);
            r_v3.ay     <= sat24(ay);
        end
    end

endmodule
`default_nettype wire

FILE: sv/obstacle_box_vertices_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_box_vertices_top
// Safety box corners of one obstacle, in body frame and rotated/translated.
// ----------------------------------------------------------------------------
// Path: the extent stages, the expander register, then the rotation's corner,
//   product, sum and output registers; three more corners follow (tlast on rear left).
// Throughput: one corner per cycle while the output is not stalled; the expander
//   takes the next item as it hands the rotation pipeline the rear left corner.
// Reset: synchronous, active low; clears all valid bits and the extent
//   registers, which read as 0 until written.
module obstacle_box_vertices_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [obv_pkg::W_ADDR-1:0] paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // rel_x, rel_y, obs_x, obs_y, cos, sin
    input  wire logic         s_axis_tuser,  // compensate
    // corner results
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // local_x, local_y, abs_x, abs_y
    output logic [1:0]        m_axis_tuser,  // corner
    output logic              m_axis_tlast
);
    import obv_pkg::*;

    t_cfg  r_cfg;
    logic  cfg_wr;
    logic [2:0] reg_idx;

    logic  ext_valid, ext_take;
    t_box  ext_box;

    t_box  r_ex_box;
    logic  r_ex_valid;
    logic [1:0] r_cnt;

    logic  rot_en;
    t_vert vert;
    logic signed [W_EXT-1:0] neg_stern, neg_sb;
    logic  out_valid;
    t_vout vout;

    // --- configuration registers ---
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MAX_BOW:        r_cfg.max_bow        <= pwdata[W_REG-1:0];
                REG_MAX_STERN:      r_cfg.max_stern      <= pwdata[W_REG-1:0];
                REG_MAX_STARBOARD:  r_cfg.max_starboard  <= pwdata[W_REG-1:0];
                REG_MAX_PORT:       r_cfg.max_port       <= pwdata[W_REG-1:0];
                REG_SAFE_BOW:       r_cfg.safe_bow       <= pwdata[W_REG-1:0];
                REG_SAFE_STERN:     r_cfg.safe_stern     <= pwdata[W_REG-1:0];
                REG_SAFE_STARBOARD: r_cfg.safe_starboard <= pwdata[W_REG-1:0];
                REG_SAFE_PORT:      r_cfg.safe_port      <= pwdata[W_REG-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_BOW:        prdata = {9'd0, r_cfg.max_bow};
            REG_MAX_STERN:      prdata = {9'd0, r_cfg.max_stern};
            REG_MAX_STARBOARD:  prdata = {9'd0, r_cfg.max_starboard};
            REG_MAX_PORT:       prdata = {9'd0, r_cfg.max_port};
            REG_SAFE_BOW:       prdata = {9'd0, r_cfg.safe_bow};
            REG_SAFE_STERN:     prdata = {9'd0, r_cfg.safe_stern};
            REG_SAFE_STARBOARD: prdata = {9'd0, r_cfg.safe_starboard};
            REG_SAFE_PORT:      prdata = {9'd0, r_cfg.safe_port};
            default:            prdata = '0;
        endcase
    end

    // --- extent selection ---
    obv_extent u_extent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_comp  (s_axis_tuser),
        .o_valid (ext_valid),
        .i_ready (ext_take),
        .o_box   (ext_box)
    );

    // --- corner expander: one box in, four corners out ---
    assign ext_take = rot_en && (!r_ex_valid || r_cnt == CORNER_RL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_cnt      <= CORNER_FR;
        end else if (rot_en) begin
            if (ext_take) begin
                r_ex_valid <= ext_valid;
                r_cnt      <= CORNER_FR;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ext_take && ext_valid) begin
            r_ex_box <= ext_box;
        end
    end

    always_comb begin
        neg_stern   = -$signed(r_ex_box.stern);
        neg_sb      = -$signed(r_ex_box.sb);
        vert.corner = r_cnt;
        vert.last   = (r_cnt == CORNER_RL);
        // front corners on bow, rear on -stern; right on -starboard, left on port
        vert.lx     = (r_cnt == CORNER_RR || r_cnt == CORNER_RL) ?
                      neg_stern[W_LEN-1:0] : r_ex_box.bow[W_LEN-1:0];
        vert.ly     = (r_cnt == CORNER_FL || r_cnt == CORNER_RL) ?
                      r_ex_box.pt[W_LEN-1:0] : neg_sb[W_LEN-1:0];
        vert.ox     = r_ex_box.ox;
        vert.oy     = r_ex_box.oy;
        vert.hc     = r_ex_box.hc;
        vert.hs     = r_ex_box.hs;
    end

    // --- rotation and output register ---
    obv_rotate u_rotate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_ex_valid),
        .i_vert      (vert),
        .i_out_ready (m_axis_tready),
        .o_en        (rot_en),
        .o_valid     (out_valid),
        .o_vout      (vout)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {vout.ay, vout.ax, vout.ly, vout.lx};
    assign m_axis_tuser  = vout.corner;
    assign m_axis_tlast  = vout.last;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the obstacle box vertices block. Obstacles go in
// over the input stream, and a local predictor works out the four corners
// that each must produce. The bench compares every corner on the result
// stream against them. Both streams stall at random. The extent registers
// are reprogrammed over APB between phases and read back in one test.
// ----------------------------------------------------------------------------
module tb_top;
    import obv_pkg::*;

    localparam int RESULT_LATENCY = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int BOX_REDUCTION  = 128;
    localparam int NUM_REGS       = 8;

    localparam logic [1:0] CORNER_ORDER [4] = '{CORNER_FR, CORNER_FL, CORNER_RR, CORNER_RL};

    typedef struct {
        logic signed [W_LEN-1:0]  rel_x;
        logic signed [W_LEN-1:0]  rel_y;
        logic                     compensate;
        logic signed [W_LEN-1:0]  obs_x;
        logic signed [W_LEN-1:0]  obs_y;
        logic signed [W_TRIG-1:0] hcos;
        logic signed [W_TRIG-1:0] hsin;
    } t_obstacle;

    typedef logic [W_REG-1:0] t_extents [NUM_REGS];

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BEAT, RX_SPARSE} t_rx_mode;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [4:0]    paddr         = '0;
    logic [31:0]   pwdata        = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata  = '0;  // rel_x, rel_y, obs_x, obs_y, cos, sin
    logic          s_axis_tuser  = 1'b0;  // compensate
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;  // local_x, local_y, abs_x, abs_y
    logic [1:0]    m_axis_tuser;  // corner
    logic          m_axis_tlast;

    logic [W_REG-1:0] extent_reg [NUM_REGS] = '{default: '0};
    t_vout            pending_corners [$];
    int               check_failures  = 0;
    int               corners_checked = 0;
    int               obstacles_sent  = 0;
    int               settings_used   = 1;
    bit               sender_gaps_on  = 1'b1;
    int               burst_left      = 0;
    bit               rx_always       = 1'b0;
    t_rx_mode         rx_mode         = RX_OPEN;
    int               rx_hold         = 0;
    int               rx_tick         = 0;

    obstacle_box_vertices_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Box corner predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [W_LEN-1:0] clamp_len(input longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[W_LEN-1:0];
    endfunction

    function automatic void predict_box_corners(input t_obstacle o);
        longint rx, ry, dx, dy, xm, xs, ym, ys, bx, by;
        longint bow, stern, sb, pt, px, py, ox, oy, hc, hs;
        longint lx [4];
        longint ly [4];
        bit     ahead, stbd, x_in, y_in, x_out, y_out;
        t_vout  v;
        rx = o.rel_x;
        ry = o.rel_y;
        ox = o.obs_x;
        oy = o.obs_y;
        hc = o.hcos;
        hs = o.hsin;
        // vehicle at the origin counts as ahead and to port
        ahead = (rx >= 0);
        stbd  = (ry < 0);
        dx = ahead ? rx : -rx;
        dy = stbd ? -ry : ry;
        xm = ahead ? extent_reg[REG_MAX_BOW] : extent_reg[REG_MAX_STERN];
        xs = ahead ? extent_reg[REG_SAFE_BOW] : extent_reg[REG_SAFE_STERN];
        ym = stbd ? extent_reg[REG_MAX_STARBOARD] : extent_reg[REG_MAX_PORT];
        ys = stbd ? extent_reg[REG_SAFE_STARBOARD] : extent_reg[REG_SAFE_PORT];
        x_in  = (dx <= xs);
        y_in  = (dy <= ys);
        x_out = (dx >= xm);
        y_out = (dy >= ym);
        // an axis beyond its max forces the other axis to its max too
        bx = xm;
        by = ym;
        if (x_in && !y_out) bx = xs;
        if (y_in && !x_out) by = ys;
        if (!y_in && !y_out && !x_out) by = dy;
        if (!x_in && !x_out && !y_out) bx = dx;
        bow   = ahead ? bx : longint'(extent_reg[REG_MAX_BOW]);
        stern = ahead ? longint'(extent_reg[REG_MAX_STERN]) : bx;
        sb    = stbd ? by : longint'(extent_reg[REG_MAX_STARBOARD]);
        pt    = stbd ? longint'(extent_reg[REG_MAX_PORT]) : by;
        if (!o.compensate) begin
            bow   -= BOX_REDUCTION;
            stern -= BOX_REDUCTION;
            sb    -= BOX_REDUCTION;
            pt    -= BOX_REDUCTION;
        end
        lx[0] = bow;    ly[0] = -sb;
        lx[1] = bow;    ly[1] = pt;
        lx[2] = -stern; ly[2] = -sb;
        lx[3] = -stern; ly[3] = pt;
        for (int k = 0; k < 4; k++) begin
            v.corner = CORNER_ORDER[k];
            v.last   = (CORNER_ORDER[k] == CORNER_RL);
            v.lx     = clamp_len(lx[k]);
            v.ly     = clamp_len(ly[k]);
            px       = $signed(v.lx);
            py       = $signed(v.ly);
            // round to nearest, halves toward +inf: floor of (p + half) / 2^14
            v.ax     = clamp_len(ox + ((hc * px - hs * py + 8192) >>> 14));
            v.ay     = clamp_len(oy + ((hs * px + hc * py + 8192) >>> 14));
            pending_corners = {pending_corners, v};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        check_failures++;
        if (check_failures <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    function automatic t_obstacle obstacle(input logic [W_LEN-1:0] rx,
                                           input logic [W_LEN-1:0] ry,
                                           input logic comp,
                                           input logic [W_LEN-1:0] ox,
                                           input logic [W_LEN-1:0] oy,
                                           input logic [W_TRIG-1:0] hc,
                                           input logic [W_TRIG-1:0] hs);
        t_obstacle o;
        o.rel_x      = rx;
        o.rel_y      = ry;
        o.compensate = comp;
        o.obs_x      = ox;
        o.obs_y      = oy;
        o.hcos       = hc;
        o.hsin       = hs;
        return o;
    endfunction

    function automatic t_extents make_extents(input logic [W_REG-1:0] mb,
                                              input logic [W_REG-1:0] ms,
                                              input logic [W_REG-1:0] msb,
                                              input logic [W_REG-1:0] mp,
                                              input logic [W_REG-1:0] sbw,
                                              input logic [W_REG-1:0] sst,
                                              input logic [W_REG-1:0] ssb,
                                              input logic [W_REG-1:0] sp);
        t_extents e;
        e[REG_MAX_BOW]        = mb;
        e[REG_MAX_STERN]      = ms;
        e[REG_MAX_STARBOARD]  = msb;
        e[REG_MAX_PORT]       = mp;
        e[REG_SAFE_BOW]       = sbw;
        e[REG_SAFE_STERN]     = sst;
        e[REG_SAFE_STARBOARD] = ssb;
        e[REG_SAFE_PORT]      = sp;
        return e;
    endfunction

    task automatic send_obstacle(input t_obstacle o);
        if (sender_gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {o.hsin, o.hcos, o.obs_y, o.obs_x, o.rel_y, o.rel_x};
        s_axis_tuser  <= o.compensate;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_box_corners(o);
        obstacles_sent++;
    endtask

    // lower valid, wait out every expected corner plus the pipeline depth
    task automatic wait_corners_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_extent(input logic [2:0] idx, input logic [W_REG-1:0] val);
        logic [8:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        extent_reg[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_extent(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {9'd0, extent_reg[idx]}) begin
            report_mismatch($sformatf("readback of register %0d", idx),
                            {9'd0, extent_reg[idx]}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_extents(input t_extents e);
        wait_corners_drained();
        for (int r = 0; r < NUM_REGS; r++) write_extent(3'(r), e[r]);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------
    // distance on one axis, biased toward the safety and max boundaries
    function automatic longint pick_distance(input longint s, input longint m);
        longint lo, hi, d;
        lo = (s < m) ? s : m;
        hi = (s < m) ? m : s;
        case ($urandom_range(0, 6))
            0: d = $urandom_range(0, 32'(lo));
            1: d = lo;
            2: d = $urandom_range(32'(lo), 32'(hi));
            3: d = hi;
            4: d = hi + $urandom_range(1, 4096);
            5: d = lo + 1;
            default: d = $urandom_range(0, 8388607);
        endcase
        return (d > 8388607) ? 8388607 : d;
    endfunction

    function automatic t_obstacle random_obstacle();
        t_obstacle o;
        longint    d;
        bit        neg;
        if ($urandom_range(0, 4) == 0) begin
            o.rel_x = $urandom;
            o.rel_y = $urandom;
        end else begin
            neg = $urandom_range(0, 1);
            d = neg ? pick_distance(extent_reg[REG_SAFE_STERN], extent_reg[REG_MAX_STERN])
                    : pick_distance(extent_reg[REG_SAFE_BOW], extent_reg[REG_MAX_BOW]);
            o.rel_x = neg ? -d : d;
            neg = $urandom_range(0, 1);
            d = neg ? pick_distance(extent_reg[REG_SAFE_STARBOARD], extent_reg[REG_MAX_STARBOARD])
                    : pick_distance(extent_reg[REG_SAFE_PORT], extent_reg[REG_MAX_PORT]);
            o.rel_y = neg ? -d : d;
        end
        o.compensate = $urandom_range(0, 1);
        case ($urandom_range(0, 19))
            0: begin
                o.obs_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                o.obs_y = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            end
            1, 2, 3: begin
                o.obs_x = $urandom;
                o.obs_y = $urandom;
            end
            default: begin
                o.obs_x = $urandom_range(0, 1048576) - 524288;
                o.obs_y = $urandom_range(0, 1048576) - 524288;
            end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            o.hcos = $urandom;
            o.hsin = $urandom;
        end else begin
            o.hcos = $urandom_range(0, 32768) - 16384;
            o.hsin = $urandom_range(0, 32768) - 16384;
        end
        return o;
    endfunction

    // max and safe registers of one side sit four indexes apart
    function automatic t_extents random_extents(input int span, input bit swap);
        t_extents         e;
        logic [W_REG-1:0] a, b;
        for (int side = 0; side < 4; side++) begin
            a = $urandom_range(0, span);
            b = $urandom_range(0, 32'(a));
            e[REG_MAX_BOW + side]  = swap ? b : a;
            e[REG_SAFE_BOW + side] = swap ? a : b;
        end
        return e;
    endfunction

    task automatic run_random_phase(input t_extents e, input int count, input bit gaps);
        apply_extents(e);
        sender_gaps_on = gaps;
        rx_always      = !gaps;
        for (int n = 0; n < count; n++) begin
            send_obstacle(random_obstacle());
            // hold the sender now and then until the block has gone idle
            if (n % 25 == 24) wait_corners_drained();
        end
        wait_corners_drained();
        sender_gaps_on = 1'b1;
        rx_always      = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // extents still at reset: every box collapses, negative once reduced
    task automatic test_reset_extents();
        send_obstacle(obstacle(0, 0, 1'b1, 0, 0, 64, 64));
        send_obstacle(obstacle(-1, -1, 1'b0, 24'h123456, -24'sh123456, 64, -64));
        send_obstacle(obstacle(24'h7FFFFF, 24'h800000, 1'b0, 0, 0, 192, -192));
        wait_corners_drained();
    endtask

    task automatic test_register_access();
        apply_extents(make_extents(23'h7FFFFF, 23'h000000, 23'h555555, 23'h2AAAAA,
                                   23'h123456, 23'h654321, 23'h7FFFFF, 23'h000001));
        for (int r = 0; r < NUM_REGS; r++) read_extent(3'(r));
        apply_extents(make_extents(23'h000000, 23'h7FFFFF, 23'h2AAAAA, 23'h555555,
                                   23'h6DCBA9, 23'h1ABCDE, 23'h000000, 23'h7FFFFE));
        for (int r = 0; r < NUM_REGS; r++) read_extent(3'(r));
    endtask

    task automatic test_extent_selection();
        apply_extents(make_extents(23'h2000, 23'h1800, 23'h1000, 23'h1400,
                                   23'h0800, 23'h0600, 23'h0400, 23'h0500));
        send_obstacle(obstacle(0, 0, 1'b1, 4096, -4096, 16384, 0));
        send_obstacle(obstacle(24'h400, -512, 1'b1, 0, 0, 16384, 0));
        send_obstacle(obstacle(24'h1000, 24'h300, 1'b1, 0, 0, 16384, 0));
        send_obstacle(obstacle(-1280, -2048, 1'b1, 0, 0, 0, 16384));
        wait_corners_drained();
        send_obstacle(obstacle(-4096, 24'h1000, 1'b1, 0, 0, -16384, 0));
        // one axis at its max pushes the other one out to its max as well
        send_obstacle(obstacle(24'h2000, 24'h100, 1'b1, 0, 0, 16384, 0));
        send_obstacle(obstacle(24'h100, -4096, 1'b1, 0, 0, 16384, 0));
        send_obstacle(obstacle(24'h800000, 24'h7FFFFF, 1'b1, 0, 0, 16384, 0));
        send_obstacle(obstacle(24'h800, -1024, 1'b0, 0, 0, 16384, 0));
        send_obstacle(obstacle(-1536, 24'h1300, 1'b0, 24'h10000, 24'h20000, 16384, 0));
        send_obstacle(obstacle(24'h1500, -80, 1'b1, 24'h1234, -24'sh4321, -11585, 11585));
        send_obstacle(obstacle(24'h10, 0, 1'b0, 0, 0, 11585, -11585));
        wait_corners_drained();
    endtask

    task automatic test_range_extremes();
        apply_extents(make_extents(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                                   23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF));
        send_obstacle(obstacle(0, 0, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 16384, 0));
        send_obstacle(obstacle(24'h800000, 24'h800000, 1'b0, 24'h800000, 24'h800000,
                               -16384, -16384));
        // trig words beyond unit magnitude go straight into the rotation
        send_obstacle(obstacle(24'h7FFFFF, -1, 1'b1, 0, 0, 16'h8000, 16'h7FFF));
        send_obstacle(obstacle(-3, 24'h400000, 1'b0, 0, 0, 16'h7FFF, 16'h8000));
        apply_extents(make_extents(0, 0, 0, 0, 0, 0, 0, 0));
        // reduced extents of -0.5 m put the rotated products on exact halves
        send_obstacle(obstacle(5, -5, 1'b0, 24'h7FFFFF, 24'h800000, -64, 192));
        send_obstacle(obstacle(-5, 5, 1'b0, 0, 0, 1, -1));
        wait_corners_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(random_extents(32'h40000, 1'b0), 49, 1'b1);
        run_random_phase(random_extents(32'h40000, 1'b1), 49, 1'b1);
        run_random_phase(random_extents(32'h7FFFFF, 1'b0), 49, 1'b0);
        run_random_phase(make_extents(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                                      23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF),
                         49, 1'b1);
        run_random_phase(make_extents(0, 0, 0, 0, 0, 0, 0, 0), 49, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and corner checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 80);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        rx_tick <= rx_tick + 1;
        if (rx_always) begin
            m_axis_tready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                RX_BEAT:   m_axis_tready <= (rx_tick % 3 != 0);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : corner_check
        t_vout want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            corners_checked++;
            if (pending_corners.size() == 0) begin
                report_mismatch("corner with no obstacle pending", '0, m_axis_tdata[31:0]);
            end else begin
                want = pending_corners.pop_front();
                if (m_axis_tuser !== want.corner)
                    report_mismatch("corner code", want.corner, m_axis_tuser);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last flag", want.last, m_axis_tlast);
                if (m_axis_tdata[23:0] !== want.lx)
                    report_mismatch("local_x", want.lx, m_axis_tdata[23:0]);
                if (m_axis_tdata[47:24] !== want.ly)
                    report_mismatch("local_y", want.ly, m_axis_tdata[47:24]);
                if (m_axis_tdata[71:48] !== want.ax)
                    report_mismatch("abs_x", want.ax, m_axis_tdata[71:48]);
                if (m_axis_tdata[95:72] !== want.ay)
                    report_mismatch("abs_y", want.ay, m_axis_tdata[95:72]);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d corners outstanding", cycles,
                 pending_corners.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_extents();
        test_register_access();
        test_extent_selection();
        test_range_extremes();
        test_random_traffic();
        wait_corners_drained();
        if (pending_corners.size() != 0) begin
            $display("%0d expected corners never arrived", pending_corners.size());
        end
        $display("Covered %0d obstacles, %0d corner transactions, %0d extent settings,",
                 obstacles_sent, corners_checked, settings_used);
        $display("with stalls on both streams, range limits and out-of-range trig; %0d errors",
                 check_failures);
        if (check_failures == 0 && pending_corners.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/obv_pkg.sv
sv/obv_extent.sv
sv/obv_rotate.sv
sv/obstacle_box_vertices_top.sv
sim/tb_top.sv
